>>> rtl/apt3d_pkg.sv
// shared types, constants and helpers for the 3d affine point transform unit
// no dependencies; every rtl file of the block imports this package
package apt3d_pkg;

   localparam int COORD_W    = 32;               // signed q16.16 coordinate
   localparam int COEF_W     = 16;               // q2.14 matrix entry or q8.8 scale
   localparam int CSR_W      = 3 * COEF_W;       // widest configuration register
   localparam int NUM_AXES   = 3;
   localparam int PROD_W     = COORD_W + COEF_W; // coordinate times coefficient
   localparam int WIDE_W     = PROD_W + 2;       // room for a sum of three products
   localparam int SCALE_FRAC = 8;
   localparam int ROT_FRAC   = 14;
   localparam int SCALE_HALF = 1 << (SCALE_FRAC - 1);
   localparam int ROT_HALF   = 1 << (ROT_FRAC - 1);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic        [CSR_W-1:0]   csr_data_type;

   typedef enum logic [2:0] {
      CSR_ROTATION_ROW0         = 3'd0,
      CSR_ROTATION_ROW1         = 3'd1,
      CSR_ROTATION_ROW2         = 3'd2,
      CSR_AXIS_SCALE            = 3'd3,
      CSR_AXIS_RECIPROCAL_SCALE = 3'd4,
      CSR_OFFSET_X              = 3'd5,
      CSR_OFFSET_Y              = 3'd6,
      CSR_OFFSET_Z              = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic      operation;
      logic      is_direction;
      coord_type in_x;
      coord_type in_y;
      coord_type in_z;
   } req_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      coord_type out_z;
      logic      overflow;
   } rsp_type;

   // per-stage request flags plus the overflow gathered so far
   typedef struct packed {
      logic inverse;
      logic direction;
      logic ovf;
   } ctl_type;

   typedef struct packed {
      logic ld_raw;
      logic ld_pre;
      logic ld_prod;
   } pre_en_type;

   typedef struct packed {
      logic ld_raw;
      logic ld_out;
   } post_en_type;

   typedef struct packed {
      logic      ovf;
      coord_type val;
   } sat_type;

   // clamp a wide signed value to the coordinate range
   function automatic sat_type sat_coord(input wide_type v);
      sat_type r;
      logic    hi_same;
      hi_same = (&v[WIDE_W-1:COORD_W-1]) || !(|v[WIDE_W-1:COORD_W-1]);
      r.ovf   = !hi_same;
      if (hi_same) begin
         r.val = v[COORD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r.val = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r.val = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

>>> rtl/apt3d_pre_lane.sv
// one axis lane ahead of the rotation: scale or offset removal, then its
// three matrix products; depends on apt3d_pkg
module apt3d_pre_lane #(
   parameter int LANE = 0
) (
   input  logic                 clock,
   input  apt3d_pkg::pre_en_type en,
   input  apt3d_pkg::ctl_type   ctl_in_stage,
   input  apt3d_pkg::ctl_type   ctl_raw_stage,
   input  apt3d_pkg::ctl_type   ctl_pre_stage,
   input  apt3d_pkg::coord_type coord,
   input  apt3d_pkg::coef_type  scale,
   input  apt3d_pkg::coord_type offset,
   input  apt3d_pkg::coef_type  coef [apt3d_pkg::NUM_AXES][apt3d_pkg::NUM_AXES],
   output apt3d_pkg::prod_type  prod [apt3d_pkg::NUM_AXES],
   output logic                 ovf
);
   import apt3d_pkg::*;

   prod_type  raw_ff, raw_in;
   coord_type val_ff;
   logic      ovf_ff;
   prod_type  prod_ff [NUM_AXES];
   prod_type  prod_in [NUM_AXES];
   coef_type  sel     [NUM_AXES];
   wide_type  raw_wide, pre_val;
   sat_type   pre_sat;

   // raw value: scale product, offset difference or plain coordinate
   always_comb begin
      if (ctl_in_stage.direction) begin
         raw_in = prod_type'(coord);
      end else if (!ctl_in_stage.inverse) begin
         raw_in = prod_type'(coord) * prod_type'(scale);
      end else begin
         raw_in = prod_type'(coord) - prod_type'(offset);
      end
   end

   always_comb begin
      raw_wide = wide_type'(raw_ff);
      if (!ctl_raw_stage.direction && !ctl_raw_stage.inverse) begin
         pre_val = (raw_wide + wide_type'(SCALE_HALF)) >>> SCALE_FRAC;
      end else begin
         pre_val = raw_wide;
      end
      pre_sat = sat_coord(pre_val);
   end

   // transpose picks the column of this lane's row instead
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sel[i]     = ctl_pre_stage.inverse ? coef[LANE][i] : coef[i][LANE];
         prod_in[i] = prod_type'(val_ff) * prod_type'(sel[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.ld_raw) begin
         raw_ff <= raw_in;
      end
      if (en.ld_pre) begin
         val_ff <= pre_sat.val;
         ovf_ff <= pre_sat.ovf;
      end
      if (en.ld_prod) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
   assign ovf  = ovf_ff;

endmodule

>>> rtl/apt3d_merge.sv
// merging stage: sums the lane products per matrix row, rounds and clamps
// depends on apt3d_pkg
module apt3d_merge (
   input  logic                 clock,
   input  logic                 load,
   input  apt3d_pkg::prod_type  prod [apt3d_pkg::NUM_AXES][apt3d_pkg::NUM_AXES],
   output apt3d_pkg::coord_type res  [apt3d_pkg::NUM_AXES],
   output logic                 ovf
);
   import apt3d_pkg::*;

   coord_type res_ff [NUM_AXES];
   coord_type res_in [NUM_AXES];
   logic      ovf_ff, ovf_in;
   wide_type  sum    [NUM_AXES];
   sat_type   row_sat[NUM_AXES];

   // prod is indexed [lane][row]; the exact sum is rounded once
   always_comb begin
      ovf_in = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         sum[i] = wide_type'(prod[0][i]) + wide_type'(prod[1][i])
                + wide_type'(prod[2][i]) + wide_type'(ROT_HALF);
         row_sat[i] = sat_coord(sum[i] >>> ROT_FRAC);
         res_in[i]  = row_sat[i].val;
         ovf_in     = ovf_in | row_sat[i].ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign res = res_ff;
   assign ovf = ovf_ff;

endmodule

>>> rtl/apt3d_post_lane.sv
// one axis lane after the rotation: translation or reciprocal scale
// depends on apt3d_pkg
module apt3d_post_lane (
   input  logic                  clock,
   input  apt3d_pkg::post_en_type en,
   input  apt3d_pkg::ctl_type    ctl_rot_stage,
   input  apt3d_pkg::ctl_type    ctl_raw_stage,
   input  apt3d_pkg::coord_type  value,
   input  apt3d_pkg::coord_type  offset,
   input  apt3d_pkg::coef_type   scale,
   output apt3d_pkg::coord_type  result,
   output logic                  ovf
);
   import apt3d_pkg::*;

   prod_type  raw_ff, raw_in;
   coord_type out_ff;
   logic      ovf_ff;
   wide_type  raw_wide, post_val;
   sat_type   post_sat;

   always_comb begin
      if (ctl_rot_stage.direction) begin
         raw_in = prod_type'(value);
      end else if (!ctl_rot_stage.inverse) begin
         raw_in = prod_type'(value) + prod_type'(offset);
      end else begin
         raw_in = prod_type'(value) * prod_type'(scale);
      end
   end

   always_comb begin
      raw_wide = wide_type'(raw_ff);
      if (ctl_raw_stage.inverse && !ctl_raw_stage.direction) begin
         post_val = (raw_wide + wide_type'(SCALE_HALF)) >>> SCALE_FRAC;
      end else begin
         post_val = raw_wide;
      end
      post_sat = sat_coord(post_val);
   end

   always_ff @(posedge clock) begin
      if (en.ld_raw) begin
         raw_ff <= raw_in;
      end
      if (en.ld_out) begin
         out_ff <= post_sat.val;
         ovf_ff <= post_sat.ovf;
      end
   end

   assign result = out_ff;
   assign ovf    = ovf_ff;

endmodule

>>> rtl/affine_point_transform_3d_unit.sv
// top level of the 3d affine point transform: config registers, pipeline control
// depends on apt3d_pkg, apt3d_pre_lane, apt3d_merge, apt3d_post_lane
//
// usage
//  - req channel: one request per cycle carries a q16.16 triple plus the
//    inverse and direction flags; accepted when req_valid is high and
//    req_stall is low
//  - rsp channel: one response per request, in order, with the saturated
//    triple and the overflow flag; taken when rsp_valid high and rsp_stall low
//  - csr port: csr_write with csr_index and csr_wdata loads one register;
//    write only while no request is in flight
//  - throughput is one request per cycle while rsp_stall is low, set by the
//    seven-stage pipeline with three axis lanes
//  - each stage holds at most one request and moves on whenever the stage
//    after it is empty or moving, so bubbles close up under a stalled receiver
//    and req_stall rises only once every stage is full
//  - reset empties the pipeline and loads the identity transform
module affine_point_transform_3d_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  apt3d_pkg::req_type       req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output apt3d_pkg::rsp_type       rsp_payload,
   input  logic                     csr_write,
   input  apt3d_pkg::csr_index_type csr_index,
   input  apt3d_pkg::csr_data_type  csr_wdata
);
   import apt3d_pkg::*;

   // pipeline stage numbers
   localparam int ST_IN      = 0;  // request register
   localparam int ST_RAW     = 1;  // raw scale product or offset difference
   localparam int ST_PRE     = 2;  // rounded and clamped pre-rotation vector
   localparam int ST_PROD    = 3;  // nine matrix products across the lanes
   localparam int ST_ROT     = 4;  // merged rotation result
   localparam int ST_POST    = 5;  // raw translate sum or reciprocal product
   localparam int ST_OUT     = 6;  // response register
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam csr_data_type ROW0_RESET  = csr_data_type'(48'h0000_0000_4000);
   localparam csr_data_type ROW1_RESET  = csr_data_type'(48'h0000_4000_0000);
   localparam csr_data_type ROW2_RESET  = csr_data_type'(48'h4000_0000_0000);
   localparam csr_data_type SCALE_RESET = csr_data_type'(48'h0100_0100_0100);

   // configuration registers
   csr_data_type rot_row_ff [NUM_AXES];
   csr_data_type scale_ff, rscale_ff;
   coord_type    offset_ff  [NUM_AXES];

   // pipeline control
   logic [NUM_STAGES-1:0] vld_ff, vld_in, rdy, load;
   ctl_type               ctl_ff [NUM_STAGES];
   ctl_type               ctl_in [NUM_STAGES];
   req_type               in_ff;

   // unpacked config views for the lanes
   coef_type  coef        [NUM_AXES][NUM_AXES];
   coef_type  scale_f     [NUM_AXES];
   coef_type  rscale_f    [NUM_AXES];
   coord_type in_coord    [NUM_AXES];

   // lane and merge results
   prod_type    lane_prod [NUM_AXES][NUM_AXES];
   logic [NUM_AXES-1:0] pre_ovf, post_ovf;
   coord_type   rot_res   [NUM_AXES];
   logic        rot_ovf;
   coord_type   post_res  [NUM_AXES];
   pre_en_type  pre_en;
   post_en_type post_en;

   // ---------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0] <= ROW0_RESET;
         rot_row_ff[1] <= ROW1_RESET;
         rot_row_ff[2] <= ROW2_RESET;
         scale_ff      <= SCALE_RESET;
         rscale_ff     <= SCALE_RESET;
         for (int i = 0; i < NUM_AXES; i++) begin
            offset_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ROTATION_ROW0:         rot_row_ff[0] <= csr_wdata;
            CSR_ROTATION_ROW1:         rot_row_ff[1] <= csr_wdata;
            CSR_ROTATION_ROW2:         rot_row_ff[2] <= csr_wdata;
            CSR_AXIS_SCALE:            scale_ff      <= csr_wdata;
            CSR_AXIS_RECIPROCAL_SCALE: rscale_ff     <= csr_wdata;
            CSR_OFFSET_X:              offset_ff[0]  <= csr_wdata[COORD_W-1:0];
            CSR_OFFSET_Y:              offset_ff[1]  <= csr_wdata[COORD_W-1:0];
            CSR_OFFSET_Z:              offset_ff[2]  <= csr_wdata[COORD_W-1:0];
            default:                   rot_row_ff[0] <= rot_row_ff[0];
         endcase
      end
   end

   // split the packed registers into signed fields, column or axis in low bits
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            coef[i][j] = rot_row_ff[i][COEF_W*j +: COEF_W];
         end
         scale_f[i]  = scale_ff[COEF_W*i +: COEF_W];
         rscale_f[i] = rscale_ff[COEF_W*i +: COEF_W];
      end
   end

   // ---------------------------------------------------------------
   // stage handshake: a stage loads when it is empty or its content moves on
   // ---------------------------------------------------------------
   always_comb begin
      rdy[ST_OUT] = !vld_ff[ST_OUT] || !rsp_stall;
      for (int k = ST_OUT - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      load[ST_IN]   = rdy[ST_IN] && req_valid;
      vld_in[ST_IN] = rdy[ST_IN] ? req_valid : vld_ff[ST_IN];
      for (int k = 1; k < NUM_STAGES; k++) begin
         load[k]   = rdy[k] && vld_ff[k-1];
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_stall = !rdy[ST_IN];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // request flags travel with the data; overflow is folded in where found
   always_comb begin
      ctl_in[ST_IN].inverse   = req_payload.operation;
      ctl_in[ST_IN].direction = req_payload.is_direction;
      ctl_in[ST_IN].ovf       = 1'b0;
      for (int k = 1; k < NUM_STAGES; k++) begin
         ctl_in[k] = ctl_ff[k-1];
      end
      ctl_in[ST_PROD].ovf = ctl_ff[ST_PRE].ovf | (|pre_ovf);
      ctl_in[ST_POST].ovf = ctl_ff[ST_ROT].ovf | rot_ovf;
   end

   always_ff @(posedge clock) begin
      if (load[ST_IN]) begin
         in_ff <= req_payload;
      end
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            ctl_ff[k] <= ctl_in[k];
         end
      end
   end

   assign in_coord[0] = in_ff.in_x;
   assign in_coord[1] = in_ff.in_y;
   assign in_coord[2] = in_ff.in_z;

   assign pre_en.ld_raw   = load[ST_RAW];
   assign pre_en.ld_pre   = load[ST_PRE];
   assign pre_en.ld_prod  = load[ST_PROD];
   assign post_en.ld_raw  = load[ST_POST];
   assign post_en.ld_out  = load[ST_OUT];

   // ---------------------------------------------------------------
   // three axis lanes, the row merge, three output lanes
   // ---------------------------------------------------------------
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_pre
      apt3d_pre_lane #(
         .LANE (g)
      ) u_pre (
         .clock         (clock),
         .en            (pre_en),
         .ctl_in_stage  (ctl_ff[ST_IN]),
         .ctl_raw_stage (ctl_ff[ST_RAW]),
         .ctl_pre_stage (ctl_ff[ST_PRE]),
         .coord         (in_coord[g]),
         .scale         (scale_f[g]),
         .offset        (offset_ff[g]),
         .coef          (coef),
         .prod          (lane_prod[g]),
         .ovf           (pre_ovf[g])
      );
   end

   apt3d_merge u_merge (
      .clock (clock),
      .load  (load[ST_ROT]),
      .prod  (lane_prod),
      .res   (rot_res),
      .ovf   (rot_ovf)
   );

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_post
      apt3d_post_lane u_post (
         .clock         (clock),
         .en            (post_en),
         .ctl_rot_stage (ctl_ff[ST_ROT]),
         .ctl_raw_stage (ctl_ff[ST_POST]),
         .value         (rot_res[g]),
         .offset        (offset_ff[g]),
         .scale         (rscale_f[g]),
         .result        (post_res[g]),
         .ovf           (post_ovf[g])
      );
   end

   // response
   assign rsp_valid            = vld_ff[ST_OUT];
   assign rsp_payload.out_x    = post_res[0];
   assign rsp_payload.out_y    = post_res[1];
   assign rsp_payload.out_z    = post_res[2];
   assign rsp_payload.overflow = ctl_ff[ST_OUT].ovf | (|post_ovf);

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty request register never pushes back
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[ST_IN] |-> !req_stall)
      else $error("stall raised with an empty request register");

   // a held mid-pipeline stage does not lose its request
   a_hold_rot: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_ROT] && !rdy[ST_POST] |=> vld_ff[ST_ROT])
      else $error("rotation stage dropped a held request");

   // a direction never clamps before the rotation
   a_dir_no_pre_ovf: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_PRE] && ctl_ff[ST_PRE].direction |-> !(|pre_ovf))
      else $error("direction clamped ahead of the rotation");

endmodule

>>> tb/apt3d_transform_monitor.sv
// monitor for the 3d affine point transform: keeps its own register copy,
// predicts each response from the accepted request and compares field by field
// depends on apt3d_pkg
module apt3d_transform_monitor (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  apt3d_pkg::req_type       req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  apt3d_pkg::rsp_type       rsp_payload,
   input  logic                     csr_write,
   input  apt3d_pkg::csr_index_type csr_index,
   input  apt3d_pkg::csr_data_type  csr_wdata,
   output int                       mismatch_count,
   output int                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import apt3d_pkg::*;

   localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 1;
   localparam longint COORD_LO = -COORD_HI - 1;

   csr_data_type rot_rows [3];
   csr_data_type fwd_scale;
   csr_data_type inv_scale;
   coord_type    translation [3];
   rsp_type      expected_points [$];

   function automatic longint clamp_coord(input longint v, inout logic ovf);
      if (v > COORD_HI) begin
         ovf = 1'b1;
         return COORD_HI;
      end
      if (v < COORD_LO) begin
         ovf = 1'b1;
         return COORD_LO;
      end
      return v;
   endfunction

   function automatic longint coef_at(input csr_data_type word, input int k);
      coef_type c;
      c = word[k*COEF_W +: COEF_W];
      return longint'(c);
   endfunction

   function automatic longint matrix_entry(input int row, input int col, input logic transpose);
      return transpose ? coef_at(rot_rows[col], row) : coef_at(rot_rows[row], col);
   endfunction

   // q16.16 times q8.8, round half up, back to q16.16
   function automatic longint scale_one(input longint v, input longint s, inout logic ovf);
      return clamp_coord((v * s + SCALE_HALF) >>> SCALE_FRAC, ovf);
   endfunction

   // exact dot product of one matrix row (or column) and the vector, rounded once
   function automatic longint rotate_axis(input longint v0, input longint v1, input longint v2,
                                          input int row, input logic transpose,
                                          inout logic ovf);
      longint acc;
      acc = matrix_entry(row, 0, transpose) * v0 + matrix_entry(row, 1, transpose) * v1
          + matrix_entry(row, 2, transpose) * v2;
      return clamp_coord((acc + ROT_HALF) >>> ROT_FRAC, ovf);
   endfunction

   function automatic rsp_type predict_point(input req_type item);
      longint  v [3];
      longint  r [3];
      logic    ovf;
      logic    point;
      rsp_type res;
      ovf   = 1'b0;
      point = !item.is_direction;
      v[0]  = longint'(item.in_x);
      v[1]  = longint'(item.in_y);
      v[2]  = longint'(item.in_z);
      for (int i = 0; i < NUM_AXES; i++) begin
         if (point && !item.operation) begin
            v[i] = scale_one(v[i], coef_at(fwd_scale, i), ovf);
         end else if (point) begin
            v[i] = clamp_coord(v[i] - longint'(translation[i]), ovf);
         end
      end
      for (int i = 0; i < NUM_AXES; i++) begin
         r[i] = rotate_axis(v[0], v[1], v[2], i, item.operation, ovf);
      end
      for (int i = 0; i < NUM_AXES; i++) begin
         if (point && !item.operation) begin
            v[i] = clamp_coord(r[i] + longint'(translation[i]), ovf);
         end else if (point) begin
            v[i] = scale_one(r[i], coef_at(inv_scale, i), ovf);
         end else begin
            v[i] = r[i];
         end
      end
      res.out_x    = coord_type'(v[0]);
      res.out_y    = coord_type'(v[1]);
      res.out_z    = coord_type'(v[2]);
      res.overflow = ovf;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [COORD_W-1:0] want,
                                input logic [COORD_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         rot_rows[0] = 48'h0000_0000_4000;
         rot_rows[1] = 48'h0000_4000_0000;
         rot_rows[2] = 48'h4000_0000_0000;
         fwd_scale   = 48'h0100_0100_0100;
         inv_scale   = 48'h0100_0100_0100;
         for (int i = 0; i < NUM_AXES; i++) translation[i] = '0;
         expected_points.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ROTATION_ROW0:         rot_rows[0]    = csr_wdata;
               CSR_ROTATION_ROW1:         rot_rows[1]    = csr_wdata;
               CSR_ROTATION_ROW2:         rot_rows[2]    = csr_wdata;
               CSR_AXIS_SCALE:            fwd_scale      = csr_wdata;
               CSR_AXIS_RECIPROCAL_SCALE: inv_scale      = csr_wdata;
               CSR_OFFSET_X:              translation[0] = csr_wdata[COORD_W-1:0];
               CSR_OFFSET_Y:              translation[1] = csr_wdata[COORD_W-1:0];
               CSR_OFFSET_Z:              translation[2] = csr_wdata[COORD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_points.push_back(predict_point(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with nothing pending, expected none actual %h",
                        $time, rsp_payload);
            end else begin
               want = expected_points.pop_front();
               compare_field("out_x", want.out_x, rsp_payload.out_x);
               compare_field("out_y", want.out_y, rsp_payload.out_y);
               compare_field("out_z", want.out_z, rsp_payload.out_z);
               compare_field("overflow", COORD_W'(want.overflow),
                             COORD_W'(rsp_payload.overflow));
            end
         end
      end
      outstanding <= expected_points.size();
   end

endmodule

>>> tb/affine_point_transform_3d_unit_test.sv
// testbench top for the 3d affine point transform: clock, reset, stimulus and verdict
// depends on apt3d_pkg, affine_point_transform_3d_unit and apt3d_transform_monitor
module affine_point_transform_3d_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import apt3d_pkg::*;

   // request flag codes
   localparam logic OP_FORWARD     = 1'b0;
   localparam logic OP_INVERSE     = 1'b1;
   localparam logic KIND_POINT     = 1'b0;
   localparam logic KIND_DIRECTION = 1'b1;

   // register setting styles for the random phases
   localparam int STYLE_REALISTIC = 0;
   localparam int STYLE_WILD      = 1;
   localparam int STYLE_ZERO      = 2;
   localparam int STYLE_ONES      = 3;
   localparam int STYLE_TOP       = 4;
   localparam int STYLE_BOTTOM    = 5;

   localparam int NUM_REGS     = 8;
   localparam int NUM_PHASES   = 10;
   localparam int PHASE_ITEMS  = 90;
   localparam int HOLD_CYCLES  = 80;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   localparam coord_type COORD_TOP    = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_BOTTOM = {1'b1, {(COORD_W-1){1'b0}}};
   localparam coord_type COORD_UNIT   = 32'sh0001_0000;
   localparam coef_type  COEF_TOP     = 16'sh7FFF;
   localparam coef_type  COEF_BOTTOM  = 16'sh8000;
   localparam coef_type  Q214_HALF    = 16'sh2000;
   localparam coef_type  Q88_HALF     = 16'sh0080;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_write   = 1'b0;
   csr_index_type csr_index   = CSR_ROTATION_ROW0;
   csr_data_type  csr_wdata   = '0;

   int            mismatch_count;
   int            outstanding;
   int            quiet_cycles     = 0;
   int            items_sent       = 0;
   int            settings_loaded  = 0;
   bit            req_idle_on      = 1'b1;
   bit            rsp_idle_on      = 1'b1;
   bit            hold_off_request = 1'b0;
   csr_data_type  settings [NUM_REGS];

   affine_point_transform_3d_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   apt3d_transform_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #1 clock = ~clock;

   // synchronous reset, high from time zero, never raised again
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // three q2.14 or q8.8 values into one register word, first one in the low bits
   function automatic csr_data_type pack3(input coef_type c0, input coef_type c1,
                                          input coef_type c2);
      return {c2, c1, c0};
   endfunction

   // mostly values inside +-span, with the extremes and zero mixed in
   function automatic coef_type rand_coef(input int span);
      case ($urandom_range(0, 9))
         0:       return COEF_TOP;
         1:       return COEF_BOTTOM;
         2:       return '0;
         default: return coef_type'(int'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0:       return COORD_TOP;
         1:       return COORD_BOTTOM;
         2:       return coord_type'(int'($urandom_range(0, 2)) - 1);
         3, 4:    return coord_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return coord_type'($urandom);
      endcase
   endfunction

   // random offset; wild settings also put junk above bit 31 to check masking
   function automatic csr_data_type rand_offset(input bit wild);
      if (wild) return {16'($urandom), 32'($urandom)};
      return {16'h0, 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24))};
   endfunction

   task automatic choose_settings(input int style);
      int span_rot;
      int span_scl;
      bit wild;
      wild     = (style == STYLE_WILD);
      span_rot = wild ? 32768 : 16384;
      span_scl = wild ? 32768 : 512;
      case (style)
         STYLE_ZERO: begin
            for (int i = 0; i < NUM_REGS; i++) settings[i] = '0;
         end
         STYLE_ONES: begin
            for (int i = 0; i < NUM_REGS; i++) settings[i] = '1;
         end
         STYLE_TOP, STYLE_BOTTOM: begin
            for (int i = 0; i < 5; i++) begin
               settings[i] = (style == STYLE_TOP) ? pack3(COEF_TOP, COEF_TOP, COEF_TOP)
                                                  : pack3(COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM);
            end
            settings[CSR_OFFSET_X] = (style == STYLE_TOP) ? csr_data_type'(COORD_TOP)
                                                          : csr_data_type'(COORD_BOTTOM);
            settings[CSR_OFFSET_Y] = settings[CSR_OFFSET_X];
            settings[CSR_OFFSET_Z] = settings[CSR_OFFSET_X];
         end
         default: begin
            settings[CSR_ROTATION_ROW0] =
               pack3(rand_coef(span_rot), rand_coef(span_rot), rand_coef(span_rot));
            settings[CSR_ROTATION_ROW1] =
               pack3(rand_coef(span_rot), rand_coef(span_rot), rand_coef(span_rot));
            settings[CSR_ROTATION_ROW2] =
               pack3(rand_coef(span_rot), rand_coef(span_rot), rand_coef(span_rot));
            settings[CSR_AXIS_SCALE] =
               pack3(rand_coef(span_scl), rand_coef(span_scl), rand_coef(span_scl));
            settings[CSR_AXIS_RECIPROCAL_SCALE] =
               pack3(rand_coef(span_scl), rand_coef(span_scl), rand_coef(span_scl));
            settings[CSR_OFFSET_X] = rand_offset(wild);
            settings[CSR_OFFSET_Y] = rand_offset(wild);
            settings[CSR_OFFSET_Z] = rand_offset(wild);
         end
      endcase
   endtask

   // one write per edge, write enable stays high across the burst
   task automatic load_settings();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_write <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= settings[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      settings_loaded++;
   endtask

   // offer one request, maybe after a random gap, and hold it until taken
   task automatic offer(input logic op, input logic kind,
                        input coord_type x, input coord_type y, input coord_type z);
      req_type item;
      item.operation    = op;
      item.is_direction = kind;
      item.in_x         = x;
      item.in_y         = y;
      item.in_z         = z;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // stop offering and wait for every pending response; the first edge lets
   // the monitor count a request taken at the current edge
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // receiver side: random stall bursts, plus one long hold on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: any handshake or register write restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("tb: no handshake for %0d cycles", IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int   style;
      logic op;
      logic kind;
      while (reset) @(posedge clock);

      // identity transform straight out of reset: extremes pass through untouched
      offer(OP_FORWARD, KIND_POINT, '0, '0, '0);
      offer(OP_FORWARD, KIND_POINT, COORD_TOP, COORD_BOTTOM, 1);
      offer(OP_FORWARD, KIND_DIRECTION, COORD_BOTTOM, COORD_TOP, -1);
      offer(OP_INVERSE, KIND_POINT, COORD_TOP, COORD_BOTTOM, COORD_UNIT);
      offer(OP_INVERSE, KIND_DIRECTION, -1, COORD_TOP, COORD_BOTTOM);
      wait_for_drain();

      // extreme coefficients, a zero scale on one axis of each path, offsets at
      // both ends with junk above the coordinate width: saturation at every stage
      settings[CSR_ROTATION_ROW0]         = pack3(COEF_TOP, COEF_TOP, COEF_BOTTOM);
      settings[CSR_ROTATION_ROW1]         = pack3('0, COEF_BOTTOM, COEF_TOP);
      settings[CSR_ROTATION_ROW2]         = pack3(COEF_BOTTOM, coef_type'(-1), coef_type'(1));
      settings[CSR_AXIS_SCALE]            = pack3(COEF_TOP, COEF_BOTTOM, '0);
      settings[CSR_AXIS_RECIPROCAL_SCALE] = pack3(COEF_BOTTOM, '0, COEF_TOP);
      settings[CSR_OFFSET_X]              = {16'hABCD, COORD_TOP};
      settings[CSR_OFFSET_Y]              = {16'h5A5A, COORD_BOTTOM};
      settings[CSR_OFFSET_Z]              = {16'h0000, 32'h0001_2345};
      load_settings();
      for (int k = 0; k < 4; k++) begin
         op   = k[1] ? OP_INVERSE : OP_FORWARD;
         kind = k[0] ? KIND_DIRECTION : KIND_POINT;
         offer(op, kind, COORD_TOP, COORD_BOTTOM, COORD_TOP);
         offer(op, kind, COORD_UNIT, -COORD_UNIT, 32'sh0000_8000);
      end
      wait_for_drain();

      // half-way products: checks round half up on both signs
      settings[CSR_ROTATION_ROW0]         = pack3(Q214_HALF, '0, '0);
      settings[CSR_ROTATION_ROW1]         = pack3('0, -Q214_HALF, '0);
      settings[CSR_ROTATION_ROW2]         = pack3('0, '0, Q214_HALF);
      settings[CSR_AXIS_SCALE]            = pack3(Q88_HALF, -Q88_HALF, coef_type'(1));
      settings[CSR_AXIS_RECIPROCAL_SCALE] = pack3(Q88_HALF, -Q88_HALF, coef_type'(1));
      settings[CSR_OFFSET_X]              = '0;
      settings[CSR_OFFSET_Y]              = '0;
      settings[CSR_OFFSET_Z]              = '0;
      load_settings();
      offer(OP_FORWARD, KIND_POINT, 1, -1, 127);
      offer(OP_FORWARD, KIND_POINT, -1, 3, -129);
      offer(OP_INVERSE, KIND_POINT, 1, -1, 3);
      offer(OP_INVERSE, KIND_POINT, -3, 255, -255);
      offer(OP_FORWARD, KIND_DIRECTION, 1, -1, 3);
      offer(OP_INVERSE, KIND_DIRECTION, -1, 1, -3);
      wait_for_drain();

      // random phases, each under fresh register settings; the last two run
      // without any idling on either side
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            2:       style = STYLE_ZERO;
            3:       style = STYLE_ONES;
            6:       style = STYLE_TOP;
            7:       style = STYLE_BOTTOM;
            default: style = (p % 2 == 0) ? STYLE_REALISTIC : STYLE_WILD;
         endcase
         choose_settings(style);
         load_settings();
         // phase 4 keeps the sender busy so the long hold fills the pipeline
         req_idle_on = (p < 8) && (p != 4);
         rsp_idle_on = (p < 8) && (p != 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 4 && k == 5) hold_off_request = 1'b1;
            // sender pauses mid-phase until everything has come back
            if (p == 5 && k == 45) wait_for_drain();
            offer($urandom_range(0, 1) ? OP_INVERSE : OP_FORWARD,
                  $urandom_range(0, 1) ? KIND_DIRECTION : KIND_POINT,
                  rand_coord(), rand_coord(), rand_coord());
         end
         wait_for_drain();
      end

      // let any stray response show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d requests checked under %0d register settings", items_sent,
               settings_loaded);
      $display("tb: covered saturation at each stage, zero and extreme scales, full stall");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
